>>> rtl/core/idnp_pkg.sv
`timescale 1ns / 1ps

package idnp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    // results caused by one accepted byte, character first
    typedef struct packed {
        logic        has_char;
        logic [7:0]  name_char;
        logic        has_rec;
        logic [31:0] record_id;
    } res_entry_t;

endpackage

>>> rtl/core/idnp_front.sv
`timescale 1ns / 1ps

module idnp_front #(
    parameter int ID_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,
    input  logic                queue_full,
    output logic                byte_ready,
    output logic                push,
    output idnp_pkg::res_entry_t push_entry
);

    localparam logic [7:0] CH_BLANK_MAX = 8'd32;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LBRACK    = 8'h5B;
    localparam logic [7:0] CH_RBRACK    = 8'h5D;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CODE_LF      = 8'd10;
    localparam logic [7:0] CODE_CR      = 8'd13;
    localparam logic [7:0] CODE_TAB     = 8'd9;
    localparam logic [2:0] HEX_DIGITS   = 3'd4;

    typedef enum logic [3:0] {
        PH_WAIT_OPEN,
        PH_OUTER,
        PH_ID_PRE,
        PH_ID_DIG,
        PH_AFTER_ID,
        PH_NAME_PRE,
        PH_IN_STR,
        PH_SKIP_CLOSE,
        PH_DONE
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [ID_BITS-1:0]   acc_reg, acc_next;
    logic [2:0]           hex_reg, hex_next;
    logic                 esc_reg, esc_next;

    logic                 accept;
    logic                 blank;
    logic                 digit;
    logic [ID_BITS-1:0]   acc_mul;
    logic [ID_BITS+31:0]  acc_ext;
    logic [31:0]          cur_id;
    idnp_pkg::res_entry_t ent;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;
    assign blank      = data_byte <= CH_BLANK_MAX;
    assign digit      = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign acc_mul    = (acc_reg << 3) + (acc_reg << 1)
                      + {{(ID_BITS-4){1'b0}}, data_byte[3:0]};
    assign acc_ext    = {32'b0, acc_reg};
    assign cur_id     = acc_ext[31:0];

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        hex_next   = hex_reg;
        esc_next   = esc_reg;
        ent        = '0;
        case (phase_reg)
            PH_WAIT_OPEN:
            begin
                if (!blank)
                    phase_next = (data_byte == CH_LBRACK) ? PH_OUTER : PH_DONE;
            end
            PH_OUTER:
            begin
                if (!blank && data_byte != CH_COMMA)
                begin
                    if (data_byte == CH_LBRACK)
                    begin
                        acc_next   = '0;
                        phase_next = PH_ID_PRE;
                    end
                    else
                        phase_next = PH_DONE;
                end
            end
            PH_ID_PRE, PH_ID_DIG:
            begin
                if (digit)
                begin
                    acc_next   = acc_mul;
                    phase_next = PH_ID_DIG;
                end
                else if (blank)
                begin
                    if (phase_reg == PH_ID_DIG)
                        phase_next = PH_AFTER_ID;
                end
                else if (data_byte == CH_COMMA)
                    phase_next = PH_NAME_PRE;
                else
                    phase_next = (data_byte == CH_RBRACK) ? PH_OUTER : PH_SKIP_CLOSE;
            end
            PH_AFTER_ID:
            begin
                if (!blank)
                begin
                    if (data_byte == CH_COMMA)
                        phase_next = PH_NAME_PRE;
                    else
                        phase_next = (data_byte == CH_RBRACK) ? PH_OUTER : PH_SKIP_CLOSE;
                end
            end
            PH_NAME_PRE:
            begin
                if (!blank)
                begin
                    if (data_byte == CH_QUOTE)
                    begin
                        esc_next   = 1'b0;
                        hex_next   = '0;
                        phase_next = PH_IN_STR;
                    end
                    else
                    begin
                        ent.has_rec   = 1'b1;
                        ent.record_id = cur_id;
                        phase_next = (data_byte == CH_RBRACK) ? PH_OUTER : PH_SKIP_CLOSE;
                    end
                end
            end
            PH_IN_STR:
            begin
                if (hex_reg != 3'd0)
                    hex_next = hex_reg - 3'd1;
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                    case (data_byte)
                        CH_N:
                        begin
                            ent.has_char  = 1'b1;
                            ent.name_char = CODE_LF;
                        end
                        CH_R:
                        begin
                            ent.has_char  = 1'b1;
                            ent.name_char = CODE_CR;
                        end
                        CH_T:
                        begin
                            ent.has_char  = 1'b1;
                            ent.name_char = CODE_TAB;
                        end
                        CH_U:
                            hex_next = HEX_DIGITS;
                        default:
                        begin
                            ent.has_char  = 1'b1;
                            ent.name_char = data_byte;
                        end
                    endcase
                end
                else if (data_byte == CH_QUOTE)
                begin
                    ent.has_rec   = 1'b1;
                    ent.record_id = cur_id;
                    phase_next    = PH_SKIP_CLOSE;
                end
                else if (data_byte == CH_BSLASH)
                    esc_next = 1'b1;
                else
                begin
                    ent.has_char  = 1'b1;
                    ent.name_char = data_byte;
                end
            end
            PH_SKIP_CLOSE:
            begin
                if (data_byte == CH_RBRACK)
                    phase_next = PH_OUTER;
            end
            default:
                phase_next = PH_DONE;
        endcase

        if (final_byte)
        begin
            if (phase_next == PH_NAME_PRE || phase_next == PH_IN_STR)
            begin
                ent.has_rec   = 1'b1;
                ent.record_id = cur_id;
            end
            phase_next = PH_WAIT_OPEN;
            acc_next   = '0;
            hex_next   = '0;
            esc_next   = 1'b0;
        end
    end

    assign push       = accept && (ent.has_char || ent.has_rec);
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT_OPEN;
            acc_reg   <= '0;
            hex_reg   <= '0;
            esc_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            hex_reg   <= hex_next;
            esc_reg   <= esc_next;
        end
    end

endmodule

>>> rtl/core/idnp_queue.sv
`timescale 1ns / 1ps

module idnp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  idnp_pkg::res_entry_t push_entry,
    input  logic                 pop,
    output idnp_pkg::res_entry_t head_entry,
    output logic                 full,
    output logic                 empty
);

    idnp_pkg::res_entry_t              slots_reg [idnp_pkg::QUEUE_DEPTH];
    logic [idnp_pkg::QPTR_BITS-1:0]    wr_reg, rd_reg;
    logic [idnp_pkg::QCNT_BITS-1:0]    cnt_reg;

    assign full       = cnt_reg == idnp_pkg::QCNT_BITS'(idnp_pkg::QUEUE_DEPTH);
    assign empty      = cnt_reg == '0;
    assign head_entry = slots_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue read while empty");

endmodule

>>> rtl/core/idnp_back.sv
`timescale 1ns / 1ps

module idnp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  idnp_pkg::res_entry_t head_entry,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    logic        valid_reg;
    logic        kind_reg;
    logic [7:0]  char_reg;
    logic [31:0] id_reg;
    logic        last_reg;
    logic        pend_reg;
    logic [31:0] pend_id_reg;
    logic        load;

    assign load = !valid_reg || m_tready;
    assign pop  = load && !pend_reg && !empty;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {id_reg, char_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else if (!empty)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= head_entry.has_char && head_entry.has_rec;
            end
            else
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                kind_reg <= idnp_pkg::KIND_RECORD;
                char_reg <= '0;
                id_reg   <= pend_id_reg;
                last_reg <= 1'b1;
            end
            else if (head_entry.has_char)
            begin
                kind_reg    <= idnp_pkg::KIND_CHAR;
                char_reg    <= head_entry.name_char;
                id_reg      <= '0;
                last_reg    <= !head_entry.has_rec;
                pend_id_reg <= head_entry.record_id;
            end
            else
            begin
                kind_reg <= idnp_pkg::KIND_RECORD;
                char_reg <= '0;
                id_reg   <= head_entry.record_id;
                last_reg <= 1'b1;
            end
        end
    end

    a_pend_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> valid_reg)
        else $error("pending record without a word in the output stage");

    a_record_follows: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && m_tready && !last_reg |=> valid_reg && kind_reg == idnp_pkg::KIND_RECORD)
        else $error("record word missing after character word");

endmodule

>>> rtl/core/id_name_pair_list_parser.sv
`timescale 1ns / 1ps

// streaming parser for a list of [id, "name"] records: one response byte is taken per cycle
// whenever the four-entry result queue has room, and the output stage sends one result word
// per cycle while m_tready is high, so a byte that closes a record while yielding a character
// occupies two output words; with the output never stalled the sustained rate is one byte per
// cycle, and each result is written into the queue and then registered in the output stage
module id_name_pair_list_parser #(
    parameter int ID_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // name_char [7:0], record_id [39:8]
    output logic        m_tuser,   // kind
    output logic        m_tlast    // run_end
);

    idnp_pkg::res_entry_t push_entry;
    idnp_pkg::res_entry_t head_entry;
    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;

    idnp_front #(
        .ID_BITS    (ID_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .queue_full (full),
        .byte_ready (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    idnp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .full       (full),
        .empty      (empty)
    );

    idnp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
